### rtl/core/psc_pkg.sv
// ============================================================================
// psc_pkg
// Shared types, widths and codes of the pump schedule controller.
// ============================================================================
`default_nettype none

package psc_pkg;

    // register file geometry
    localparam int NUM_REGS          = 3;
    localparam int NUM_SCHEDULES_DEF = 3;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 19;

    // internal widths
    localparam int MIN_W = 11;  // minute of day, also past midnight
    localparam int DUR_W = 8;   // run length in minutes
    localparam int SEC_W = 6;   // seconds within a minute
    localparam int OT_W  = 8;   // over-temperature seconds
    localparam int REM_W = 14;  // remaining seconds
    localparam int DSP_W = 15;  // display value

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCHED_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCHED_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCHED_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OT_HOLD = 3'd5;

    // schedule reference codes
    localparam logic [1:0] ENTRY_NONE = 2'd3;

    // stop causes
    localparam logic [1:0] STOP_NONE     = 2'd0;
    localparam logic [1:0] STOP_OVERTEMP = 2'd1;
    localparam logic [1:0] STOP_EXPIRED  = 2'd2;
    localparam logic [1:0] STOP_BUTTON   = 2'd3;

    // start causes
    localparam logic [1:0] START_NONE   = 2'd0;
    localparam logic [1:0] START_MANUAL = 2'd1;
    localparam logic [1:0] START_SCHED  = 2'd2;

    localparam logic [DUR_W-1:0] MAX_DURATION     = 8'd240;
    localparam logic [DUR_W-1:0] DEFAULT_DURATION = 8'd30;
    localparam logic [SEC_W-1:0] SEC_MAX          = 6'd59;

    // input transaction
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic       time_valid;
        logic       overtemp_asserted;
        logic       button_level;
    } tick_t;

    // output transaction
    typedef struct packed {
        logic             motor_on;
        logic [REM_W-1:0] remaining_seconds;
        logic [DSP_W-1:0] display_value;
        logic [1:0]       active_schedule;
        logic [1:0]       stop_cause;
        logic [1:0]       start_cause;
    } result_t;

    // registered tick with minute of day worked out
    typedef struct packed {
        logic [MIN_W-1:0] now_min;
        logic             time_valid;
        logic             overtemp;
        logic             button;
    } stage_t;

    // sanitized schedule window in minutes of day
    typedef struct packed {
        logic [MIN_W-1:0] start_min;
        logic [MIN_W-1:0] end_min;
        logic [DUR_W-1:0] dur;
    } sched_t;

    // configuration seen by the update logic
    typedef struct packed {
        sched_t [NUM_REGS-1:0] entry;
        logic [1:0]            count;
        logic                  auto_en;
        logic [OT_W-1:0]       ot_hold;
    } cfg_t;

    // raw result in minutes and seconds
    typedef struct packed {
        logic             motor_on;
        logic [DUR_W-1:0] rem_min;
        logic [SEC_W-1:0] rem_sec;
        logic [1:0]       active_schedule;
        logic [1:0]       stop_cause;
        logic [1:0]       start_cause;
    } raw_t;

endpackage

`default_nettype wire

### rtl/core/psc_cfg.sv
// ============================================================================
// psc_cfg
// Configuration registers; schedule entries are sanitized and stored as
// start and end minute of day when written.
// ============================================================================
`default_nettype none

module psc_cfg
    import psc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output logic [NUM_REGS-1:0]   entry_written
);

    localparam logic [CFG_DATA_W-1:0] ENTRY_RESET = 19'd30;

    // replace bad fields with defaults and convert to minutes of day
    function automatic sched_t decode_entry(logic [CFG_DATA_W-1:0] v);
        logic [4:0]       h;
        logic [5:0]       m;
        logic [DUR_W-1:0] d;
        sched_t           s;
        h = v[18:14];
        m = v[13:8];
        d = v[7:0];
        if (h > 5'd23)
            h = '0;
        if (m > 6'd59)
            m = '0;
        if (d == '0 || d > MAX_DURATION)
            d = DEFAULT_DURATION;
        s.start_min = MIN_W'(h) * MIN_W'(60) + MIN_W'(m);
        s.end_min   = s.start_min + MIN_W'(d);
        s.dur       = d;
        return s;
    endfunction

    sched_t [NUM_REGS-1:0] entry_reg;
    logic [1:0]            count_reg;
    logic                  auto_reg;
    logic [OT_W-1:0]       hold_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_REGS; j++)
            begin
                entry_reg[j] <= decode_entry(ENTRY_RESET);
            end
            count_reg <= '0;
            auto_reg  <= 1'b0;
            hold_reg  <= 8'd2;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index) inside
                REG_SCHED_0, REG_SCHED_1, REG_SCHED_2:
                    entry_reg[cfg_index[1:0]] <= decode_entry(cfg_data);
                REG_COUNT:   count_reg <= cfg_data[1:0];
                REG_AUTO:    auto_reg  <= cfg_data[0];
                REG_OT_HOLD: hold_reg  <= cfg_data[OT_W-1:0];
                default:     ;
            endcase
        end
    end

    // pulse per entry write, used to unblock that entry
    always_comb
    begin
        for (int j = 0; j < NUM_REGS; j++)
        begin
            entry_written[j] = cfg_valid && (cfg_index == REG_SCHED_0 + CFG_IDX_W'(j));
        end
    end

    assign cfg.entry   = entry_reg;
    assign cfg.count   = count_reg;
    assign cfg.auto_en = auto_reg;
    assign cfg.ot_hold = hold_reg;

endmodule

`default_nettype wire

### rtl/core/psc_core.sv
// ============================================================================
// psc_core
// Per-tick update: over-temperature, countdown, button, schedule match and
// window clearing, with the controller state and the raw result register.
// ============================================================================
`default_nettype none

module psc_core
    import psc_pkg::*;
#(
    parameter int NUM_ACTIVE = NUM_REGS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  stage_t              stage_in,
    input  cfg_t                cfg,
    input  logic [NUM_REGS-1:0] entry_written,
    input  logic                drain,
    output logic                res_valid,
    output raw_t                res
);

    // controller state
    logic                  motor_running_reg;
    logic [DUR_W-1:0]      rem_min_reg;
    logic [SEC_W-1:0]      rem_sec_reg;
    logic [1:0]            cur_reg;
    logic [NUM_ACTIVE-1:0] comp_reg;
    logic [NUM_ACTIVE-1:0] blk_reg;
    logic [DUR_W-1:0]      manual_min_reg;
    logic [OT_W-1:0]       ot_elapsed_reg;
    logic                  ot_tracking_reg;
    logic                  last_button_reg;
    logic                  res_valid_reg;
    raw_t                  res_reg;

    // next values
    logic                  motor_running_next;
    logic [DUR_W-1:0]      rem_min_next;
    logic [SEC_W-1:0]      rem_sec_next;
    logic [1:0]            cur_next;
    logic [NUM_ACTIVE-1:0] comp_next;
    logic [NUM_ACTIVE-1:0] blk_next;
    logic [DUR_W-1:0]      manual_min_next;
    logic [OT_W-1:0]       ot_elapsed_next;
    logic                  ot_tracking_next;
    raw_t                  res_next;

    // intermediate terms
    logic                  ot_stop, cd_stop, btn_stop, btn_start, halt;
    logic                  run1, run2, run3, press;
    logic [DUR_W-1:0]      dec_min;
    logic [SEC_W-1:0]      dec_sec;
    logic                  found, sched_start;
    logic [NUM_ACTIVE-1:0] hit_oh, in_use;
    logic [MIN_W-1:0]      hit_end;
    logic [DUR_W-1:0]      hit_dur;
    logic [1:0]            hit_code, stop_code;

    always_comb
    begin
        // over-temperature tracking
        if (stage_in.overtemp)
        begin
            ot_tracking_next = 1'b1;
            if (!ot_tracking_reg)
                ot_elapsed_next = '0;
            else if (ot_elapsed_reg != '1)
                ot_elapsed_next = ot_elapsed_reg + 1'b1;
            else
                ot_elapsed_next = ot_elapsed_reg;
        end
        else
        begin
            ot_tracking_next = 1'b0;
            ot_elapsed_next  = '0;
        end
        ot_stop = stage_in.overtemp && (ot_elapsed_next > cfg.ot_hold) && motor_running_reg;
        run1    = motor_running_reg && !ot_stop;

        // one-second countdown
        if (rem_sec_reg != '0)
        begin
            dec_min = rem_min_reg;
            dec_sec = rem_sec_reg - 1'b1;
        end
        else if (rem_min_reg != '0)
        begin
            dec_min = rem_min_reg - 1'b1;
            dec_sec = SEC_MAX;
        end
        else
        begin
            dec_min = '0;
            dec_sec = '0;
        end
        cd_stop = run1 && (dec_min == '0) && (dec_sec == '0);
        run2    = run1 && !cd_stop;

        // button falling edge toggles the motor
        press     = last_button_reg && !stage_in.button;
        btn_start = press && !run2;
        btn_stop  = press && run2;
        run3      = btn_start || (run2 && !btn_stop);
        halt      = ot_stop || cd_stop || btn_stop;

        if (btn_stop)
            stop_code = STOP_BUTTON;
        else if (cd_stop)
            stop_code = STOP_EXPIRED;
        else if (ot_stop)
            stop_code = STOP_OVERTEMP;
        else
            stop_code = STOP_NONE;

        // apply stop and manual start
        comp_next       = comp_reg;
        blk_next        = blk_reg;
        cur_next        = cur_reg;
        manual_min_next = manual_min_reg;
        if (halt)
        begin
            for (int j = 0; j < NUM_ACTIVE; j++)
            begin
                if (cur_reg == 2'(j))
                begin
                    comp_next[j] = 1'b1;
                    blk_next[j]  = 1'b1;
                end
            end
            cur_next = ENTRY_NONE;
        end
        if (btn_start)
        begin
            rem_min_next = manual_min_reg;
            rem_sec_next = '0;
        end
        else if (run3)
        begin
            rem_min_next = dec_min;
            rem_sec_next = dec_sec;
        end
        else
        begin
            rem_min_next = '0;
            rem_sec_next = '0;
        end
        motor_running_next = run3;

        // first window holding the current minute
        found    = 1'b0;
        hit_oh   = '0;
        hit_end  = '0;
        hit_dur  = '0;
        hit_code = ENTRY_NONE;
        for (int i = 0; i < NUM_ACTIVE; i++)
        begin
            in_use[i] = cfg.count > 2'(i);
            if (!found && in_use[i]
                && stage_in.now_min >= cfg.entry[i].start_min
                && stage_in.now_min <  cfg.entry[i].end_min)
            begin
                found     = 1'b1;
                hit_oh[i] = 1'b1;
                hit_end   = cfg.entry[i].end_min;
                hit_dur   = cfg.entry[i].dur;
                hit_code  = 2'(i);
            end
        end
        sched_start = stage_in.time_valid && found && cfg.auto_en && !run3
                      && ((hit_oh & (comp_next | blk_next)) == '0);
        if (sched_start)
        begin
            motor_running_next = 1'b1;
            rem_min_next       = DUR_W'(hit_end - stage_in.now_min);
            rem_sec_next       = '0;
            manual_min_next    = hit_dur;
            cur_next           = hit_code;
            comp_next          = comp_next | hit_oh;
        end

        // windows already passed release their flags
        for (int i = 0; i < NUM_ACTIVE; i++)
        begin
            if (stage_in.time_valid && in_use[i] && stage_in.now_min >= cfg.entry[i].end_min)
            begin
                comp_next[i] = 1'b0;
                blk_next[i]  = 1'b0;
            end
        end

        // raw result
        res_next.motor_on        = motor_running_next;
        res_next.rem_min         = rem_min_next;
        res_next.rem_sec         = rem_sec_next;
        res_next.active_schedule = cur_next;
        res_next.stop_cause      = stop_code;
        if (sched_start)
            res_next.start_cause = START_SCHED;
        else if (btn_start)
            res_next.start_cause = START_MANUAL;
        else
            res_next.start_cause = START_NONE;
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_running_reg <= 1'b0;
            rem_min_reg       <= '0;
            rem_sec_reg       <= '0;
            cur_reg           <= ENTRY_NONE;
            comp_reg          <= '0;
            blk_reg           <= '0;
            manual_min_reg    <= DEFAULT_DURATION;
            ot_elapsed_reg    <= '0;
            ot_tracking_reg   <= 1'b0;
            last_button_reg   <= 1'b1;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                motor_running_reg <= motor_running_next;
                rem_min_reg       <= rem_min_next;
                rem_sec_reg       <= rem_sec_next;
                cur_reg           <= cur_next;
                comp_reg          <= comp_next;
                manual_min_reg    <= manual_min_next;
                ot_elapsed_reg    <= ot_elapsed_next;
                ot_tracking_reg   <= ot_tracking_next;
                last_button_reg   <= stage_in.button;
            end
            // entry writes unblock their schedule
            blk_reg       <= (step ? blk_next : blk_reg) & ~entry_written[NUM_ACTIVE-1:0];
            res_valid_reg <= step || (res_valid_reg && !drain);
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // stopped motor carries no count and no schedule
    a_stopped_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !motor_running_reg |-> (rem_min_reg == '0 && rem_sec_reg == '0
                                && cur_reg == ENTRY_NONE))
        else $error("stopped motor with leftover count or schedule");

    // count stays within the longest run
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_sec_reg <= SEC_MAX && rem_min_reg <= MAX_DURATION)
        else $error("remaining count out of range");

    // a schedule start always names its schedule
    a_sched_named: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.start_cause == START_SCHED
        |-> res_reg.motor_on && res_reg.active_schedule != ENTRY_NONE)
        else $error("schedule start without schedule");

    // state moves only on a tick
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(motor_running_reg) && $stable(rem_min_reg)
                  && $stable(rem_sec_reg) && $stable(comp_reg))
        else $error("state changed without a tick");

endmodule

`default_nettype wire

### rtl/core/psc_fmt.sv
// ============================================================================
// psc_fmt
// Output stage: converts minutes and seconds to the result fields and holds
// the result transaction until it is taken.
// ============================================================================
`default_nettype none

module psc_fmt
    import psc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    input  raw_t    res,
    output logic    free,
    output logic    result_valid,
    output result_t result,
    input  logic    result_ready
);

    logic    out_valid_reg;
    result_t out_reg;
    result_t out_next;
    logic    load;

    assign free = !out_valid_reg || result_ready;
    assign load = res_valid && free;

    // seconds and display form
    always_comb
    begin
        out_next.motor_on          = res.motor_on;
        out_next.remaining_seconds = REM_W'(res.rem_min) * REM_W'(60) + REM_W'(res.rem_sec);
        out_next.display_value     = DSP_W'(res.rem_min) * DSP_W'(100) + DSP_W'(res.rem_sec);
        out_next.active_schedule   = res.active_schedule;
        out_next.stop_cause        = res.stop_cause;
        out_next.start_cause       = res.start_cause;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= load || (out_valid_reg && !result_ready);
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

### rtl/core/pump_schedule_controller.sv
// ============================================================================
// pump_schedule_controller
// Pump motor controller updated once per one-second tick transaction.
// ============================================================================
// Path: result_valid rises once a taken tick has passed the tick, state/result
// and output registers. Throughput: one tick per cycle unless result_ready
// stalls; three register stages, ready flows back through all three.
// Reset: rst_n clears all control state and loads the register defaults;
// configuration writes are taken in every cycle.
`default_nettype none

module pump_schedule_controller
    import psc_pkg::*;
#(
    parameter int NUM_SCHEDULES = NUM_SCHEDULES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    output logic                  tick_ready,
    input  tick_t                 tick,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NUM_ACTIVE = (NUM_SCHEDULES < NUM_REGS) ? NUM_SCHEDULES : NUM_REGS;

    cfg_t                cfg;
    logic [NUM_REGS-1:0] entry_written;
    logic                a_valid_reg;
    stage_t              a_reg;
    stage_t              a_next;
    logic                res_valid;
    raw_t                res;
    logic                free;
    logic                b_ready;
    logic                step;
    logic                accept;

    assign cfg_ready = 1'b1;

    // pipeline handshake
    assign b_ready    = !res_valid || free;
    assign step       = a_valid_reg && b_ready;
    assign tick_ready = !a_valid_reg || b_ready;
    assign accept     = tick_valid && tick_ready;

    // minute of day of the incoming tick
    always_comb
    begin
        a_next.now_min    = MIN_W'(tick.hour) * MIN_W'(60) + MIN_W'(tick.minute);
        a_next.time_valid = tick.time_valid;
        a_next.overtemp   = tick.overtemp_asserted;
        a_next.button     = tick.button_level;
    end

    // tick stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= accept || (a_valid_reg && !step);
    end

    // tick stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
            a_reg <= a_next;
    end

    psc_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cfg           (cfg),
        .entry_written (entry_written)
    );

    psc_core #(
        .NUM_ACTIVE (NUM_ACTIVE)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .stage_in      (a_reg),
        .cfg           (cfg),
        .entry_written (entry_written),
        .drain         (res_valid && free),
        .res_valid     (res_valid),
        .res           (res)
    );

    psc_fmt u_fmt (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res          (res),
        .free         (free),
        .result_valid (result_valid),
        .result       (result),
        .result_ready (result_ready)
    );

endmodule

`default_nettype wire
